// ----- hw/rtl/disk_seek_order_scheduler_assert.svh -----
// assertion macros for the disk seek order scheduler
`ifndef DISK_SEEK_ORDER_SCHEDULER_ASSERT_SVH
`define DISK_SEEK_ORDER_SCHEDULER_ASSERT_SVH
`ifndef SYNTHESIS
`define DSOS_CHECK_NOW(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("dsos check failed");
`define DSOS_CHECK_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("dsos check failed");
`else
`define DSOS_CHECK_NOW(label, pre, post)
`define DSOS_CHECK_NEXT(label, pre, post)
`endif
`endif

// ----- hw/rtl/dsos_pkg.sv -----
// shared types and constants of the disk seek order scheduler
`default_nettype none
package dsos_pkg;
	localparam int MAX_REQUESTS = 32;
	localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
	localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
	localparam int CYL_W = 16;
	localparam int TOT_W = 22;
	localparam int KEY_W = CYL_W + IDX_W;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [1:0] MODE_FCFS = 2'd0;
	localparam logic [1:0] MODE_SCAN = 2'd1;
	localparam logic [1:0] MODE_CSCAN = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DISK_MAX = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEAD_START = 2'd2;

	typedef struct packed {
		logic [CYL_W-1:0] cylinder;
		logic last;
	} req_t;

	typedef struct packed {
		logic [CYL_W-1:0] from_pos;
		logic [CYL_W-1:0] to_pos;
		logic [CYL_W-1:0] distance;
		logic [TOT_W-1:0] total_seek;
		logic end_of_run;
	} move_t;

	typedef struct packed {
		logic [CYL_W-1:0] pos;
		logic last;
	} point_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [CYL_W-1:0] disk_max;
		logic [CYL_W-1:0] head_start;
	} cfg_t;
endpackage
`default_nettype wire

// ----- hw/rtl/dsos_ram.sv -----
// generic single write port ram with registered read
`default_nettype none
module dsos_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic clk,
	input  logic we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// ----- hw/rtl/dsos_front.sv -----
// request loader and service order sequencer feeding the point queue
`default_nettype none
module dsos_front import dsos_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  logic   req_valid,
	output logic   req_ready,
	input  req_t   req,
	output logic   push,
	output point_t push_point,
	input  logic   full
);
	localparam logic [2:0] S_LOAD   = 3'd0;
	localparam logic [2:0] S_HEAD   = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_PICK   = 3'd3;
	localparam logic [2:0] S_MAX    = 3'd4;
	localparam logic [2:0] S_ZERO   = 3'd5;
	localparam logic [2:0] S_FINISH = 3'd6;

	localparam logic [1:0] PH_ALL = 2'd0;
	localparam logic [1:0] PH_HI  = 2'd1;
	localparam logic [1:0] PH_LO  = 2'd2;

	logic [2:0]       state_q;
	logic [1:0]       ph_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] addr_q;
	logic             rd_v_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             first_q;
	logic             found_q;
	logic [KEY_W-1:0] prev_key_q;
	logic [KEY_W-1:0] best_key_q;
	logic [CYL_W-1:0] best_pos_q;
	logic [CYL_W-1:0] pend_q;

	logic             accept;
	logic             wr_en;
	logic             issue;
	logic             pass_done;
	logic [CYL_W-1:0] rd_data;
	logic             below;
	logic             elig;
	logic             desc;
	logic [KEY_W-1:0] key;
	logic             after;
	logic             better;
	logic             take;
	logic             sweep;

	assign req_ready = (state_q == S_LOAD);
	assign accept    = req_valid && req_ready;
	assign wr_en     = accept && (count_q < CNT_W'(MAX_REQUESTS));
	assign issue     = (state_q == S_SCAN) && (addr_q < count_q);
	assign pass_done = (state_q == S_SCAN) && !issue && !rd_v_s1;
	assign sweep     = (cfg.mode == MODE_SCAN) || (cfg.mode == MODE_CSCAN);

	dsos_ram #(
		.WIDTH(CYL_W),
		.DEPTH(MAX_REQUESTS)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(count_q[IDX_W-1:0]),
		.wdata(req.cylinder),
		.re   (issue),
		.raddr(addr_q[IDX_W-1:0]),
		.rdata(rd_data)
	);

	// selection key: index alone in the fcfs pass, else value then index, so equal cylinders still come out once each
	always_comb begin
		below = rd_data < cfg.head_start;
		unique case (ph_q)
			PH_ALL: elig = 1'b1;
			PH_HI: elig = !below;
			PH_LO: elig = below;
			default: elig = 1'b0;
		endcase
		key    = (ph_q == PH_ALL) ? {{CYL_W{1'b0}}, idx_s1} : {rd_data, idx_s1};
		desc   = (ph_q == PH_LO) && (cfg.mode == MODE_SCAN);
		after  = first_q || (desc ? (key < prev_key_q) : (key > prev_key_q));
		better = !found_q || (desc ? (key > best_key_q) : (key < best_key_q));
		take   = rd_v_s1 && elig && after && better;
	end

	always_comb begin
		push       = 1'b0;
		push_point = '{pos: pend_q, last: 1'b0};
		unique case (state_q) inside
			S_PICK: push = found_q && !full;
			S_MAX, S_ZERO: push = !full;
			S_FINISH: begin
				push            = !full;
				push_point.last = 1'b1;
			end
			default: push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			ph_q    <= PH_ALL;
			count_q <= '0;
			addr_q  <= '0;
			rd_v_s1 <= 1'b0;
			first_q <= 1'b1;
			found_q <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
			if (wr_en) begin
				count_q <= count_q + 1'b1;
			end
			unique case (state_q)
				S_LOAD: begin
					if (accept && req.last) begin
						state_q <= S_HEAD;
					end
				end
				S_HEAD: begin
					ph_q    <= sweep ? PH_HI : PH_ALL;
					first_q <= 1'b1;
					found_q <= 1'b0;
					addr_q  <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (issue) begin
						addr_q <= addr_q + 1'b1;
					end
					if (take) begin
						found_q <= 1'b1;
					end
					if (pass_done) begin
						state_q <= S_PICK;
					end
				end
				S_PICK: begin
					if (found_q) begin
						if (!full) begin
							first_q <= 1'b0;
							found_q <= 1'b0;
							addr_q  <= '0;
							state_q <= S_SCAN;
						end
					end else if (ph_q == PH_HI) begin
						state_q <= S_MAX;
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_MAX: begin
					if (!full) begin
						if (cfg.mode == MODE_CSCAN) begin
							state_q <= S_ZERO;
						end else begin
							ph_q    <= PH_LO;
							first_q <= 1'b1;
							addr_q  <= '0;
							state_q <= S_SCAN;
						end
					end
				end
				S_ZERO: begin
					if (!full) begin
						ph_q    <= PH_LO;
						first_q <= 1'b1;
						addr_q  <= '0;
						state_q <= S_SCAN;
					end
				end
				S_FINISH: begin
					if (!full) begin
						count_q <= '0;
						state_q <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// payload side: pending point and best candidate of the current pass
	always_ff @(posedge clk) begin
		idx_s1 <= addr_q[IDX_W-1:0];
		if (take) begin
			best_key_q <= key;
			best_pos_q <= rd_data;
		end
		unique case (state_q)
			S_HEAD: pend_q <= cfg.head_start;
			S_PICK: begin
				if (found_q && !full) begin
					pend_q     <= best_pos_q;
					prev_key_q <= best_key_q;
				end
			end
			S_MAX: begin
				if (!full) begin
					pend_q <= cfg.disk_max;
				end
			end
			S_ZERO: begin
				if (!full) begin
					pend_q <= '0;
				end
			end
			default: pend_q <= pend_q;
		endcase
	end
endmodule
`default_nettype wire

// ----- hw/rtl/dsos_queue.sv -----
// short queue of service points between sequencer and move emitter
`default_nettype none
module dsos_queue import dsos_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  point_t push_point,
	output logic   full,
	input  logic   pop,
	output point_t pop_point,
	output logic   empty
);
	point_t            entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full      = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty     = (cnt_q == '0);
	assign pop_point = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_point;
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/dsos_back.sv -----
// move emitter: turns service points into head moves with running seek total
`default_nettype none
module dsos_back import dsos_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  point_t pop_point,
	input  logic   empty,
	output logic   pop,
	output logic   move_valid,
	input  logic   move_ready,
	output move_t  move
);
	logic             first_q;
	logic             move_valid_q;
	move_t            move_q;
	logic [CYL_W-1:0] cur_q;
	logic [TOT_W-1:0] tot_q;
	logic [CYL_W-1:0] seek_len;
	logic [TOT_W-1:0] tot_next;

	// the first point of a batch is the start position and makes no move
	assign pop      = !empty && (first_q || !move_valid_q || move_ready);
	assign seek_len = (cur_q > pop_point.pos) ? (cur_q - pop_point.pos)
	                                          : (pop_point.pos - cur_q);
	assign tot_next = tot_q + TOT_W'(seek_len);

	assign move_valid = move_valid_q;
	assign move       = move_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q      <= 1'b1;
			move_valid_q <= 1'b0;
		end else begin
			if (move_ready) begin
				move_valid_q <= 1'b0;
			end
			if (pop) begin
				if (first_q) begin
					first_q <= 1'b0;
				end else begin
					move_valid_q <= 1'b1;
					if (pop_point.last) begin
						first_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_point.pos;
			if (first_q) begin
				tot_q <= '0;
			end else begin
				tot_q             <= tot_next;
				move_q.from_pos   <= cur_q;
				move_q.to_pos     <= pop_point.pos;
				move_q.distance   <= seek_len;
				move_q.total_seek <= tot_next;
				move_q.end_of_run <= pop_point.last;
			end
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/disk_seek_order_scheduler.sv -----
// Disk seek order scheduler. Cylinder requests load one per cycle into a
// 32-entry store until an item with last set arrives; further requests past
// a full store are dropped. The block then emits moves in first come first
// served, SCAN or circular SCAN order, starting at head_start. Each service
// point is chosen by a full pass over the store through its single read
// port, and the next point is not chosen before that pass is done;
// requests are not accepted while a batch is being ordered, and a
// four-entry point queue lets the move output stall on its own. There is no
// clearing pass after reset. Configuration writes (mode, disk_max,
// head_start) take effect at once and belong between batches.
`default_nettype none
`include "disk_seek_order_scheduler_assert.svh"
module disk_seek_order_scheduler import dsos_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  req_t                  req,
	output logic                  move_valid,
	input  logic                  move_ready,
	output move_t                 move
);
	cfg_t   cfg_q;
	logic   push;
	point_t push_point;
	logic   full;
	logic   pop;
	point_t pop_point;
	logic   empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode       <= MODE_FCFS;
			cfg_q.disk_max   <= '1;
			cfg_q.head_start <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE: cfg_q.mode <= cfg_wdata[1:0];
				REG_DISK_MAX: cfg_q.disk_max <= cfg_wdata[CYL_W-1:0];
				REG_HEAD_START: cfg_q.head_start <= cfg_wdata[CYL_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	dsos_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.push      (push),
		.push_point(push_point),
		.full      (full)
	);

	dsos_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_point(push_point),
		.full      (full),
		.pop       (pop),
		.pop_point (pop_point),
		.empty     (empty)
	);

	dsos_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_point (pop_point),
		.empty     (empty),
		.pop       (pop),
		.move_valid(move_valid),
		.move_ready(move_ready),
		.move      (move)
	);

	`DSOS_CHECK_NOW(a_no_push_full, push, !full)
	`DSOS_CHECK_NOW(a_no_pop_empty, pop, !empty)
	`DSOS_CHECK_NEXT(a_reload_after_batch, push && push_point.last, req_ready)
	`DSOS_CHECK_NOW(a_total_covers_move, move_valid, move.total_seek >= TOT_W'(move.distance))
endmodule
`default_nettype wire

// ----- sim/tb_disk_seek_order_scheduler.sv -----
// self-checking testbench for the disk seek order scheduler: random batches, all modes
module tb_disk_seek_order_scheduler;
	import dsos_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 5000;
	localparam int ITEM_GOAL = 350;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AFTER = 150;
	localparam int CALM_FROM = 3000;
	localparam int CALM_TO = 6000;
	localparam int SETTLE_CYCLES = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic move_valid;
	logic move_ready = 1'b0;
	move_t move;

	// local copy of the configuration registers
	logic [1:0] cfg_mode = MODE_FCFS;
	logic [CYL_W-1:0] cfg_disk_max = 16'hFFFF;
	logic [CYL_W-1:0] cfg_head = '0;

	req_t pending_reqs[$];
	logic [CYL_W-1:0] batch_cyls[$];
	move_t moves_due[$];
	move_t want;

	int items_queued = 0;
	int items_taken = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	int cycle_count = 0;
	int stall_left = 0;
	bit stall_done = 1'b0;
	bit req_took = 1'b0;

	disk_seek_order_scheduler dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.move_valid(move_valid),
		.move_ready(move_ready),
		.move(move)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// stores one request and, on the last of a batch, lays out every move it causes
	task automatic take_request(input req_t r);
		logic [CYL_W-1:0] ordered [0:MAX_REQUESTS-1];
		logic [CYL_W-1:0] path [0:MAX_REQUESTS+2];
		logic [CYL_W-1:0] key;
		logic [CYL_W-1:0] seek_len;
		logic [TOT_W-1:0] run_total;
		int n, n_path, split, i, j;
		move_t m;
		if (batch_cyls.size() < MAX_REQUESTS)
			batch_cyls.push_back(r.cylinder);
		if (r.last) begin
			n = batch_cyls.size();
			path[0] = cfg_head;
			n_path = 1;
			if (cfg_mode == MODE_SCAN || cfg_mode == MODE_CSCAN) begin
				for (i = 0; i < n; i++) begin
					key = batch_cyls[i];
					j = i;
					while (j > 0 && ordered[j-1] > key) begin
						ordered[j] = ordered[j-1];
						j--;
					end
					ordered[j] = key;
				end
				// requests equal to the head go with the upper sweep
				split = 0;
				while (split < n && ordered[split] < cfg_head)
					split++;
				for (i = split; i < n; i++) begin
					path[n_path] = ordered[i];
					n_path++;
				end
				path[n_path] = cfg_disk_max;
				n_path++;
				if (cfg_mode == MODE_CSCAN) begin
					path[n_path] = '0;
					n_path++;
					for (i = 0; i < split; i++) begin
						path[n_path] = ordered[i];
						n_path++;
					end
				end else begin
					for (i = split - 1; i >= 0; i--) begin
						path[n_path] = ordered[i];
						n_path++;
					end
				end
			end else begin
				for (i = 0; i < n; i++) begin
					path[n_path] = batch_cyls[i];
					n_path++;
				end
			end
			run_total = '0;
			for (i = 0; i + 1 < n_path; i++) begin
				seek_len = (path[i] > path[i+1]) ? path[i] - path[i+1]
					: path[i+1] - path[i];
				run_total = run_total + TOT_W'(seek_len);
				m.from_pos = path[i];
				m.to_pos = path[i+1];
				m.distance = seek_len;
				m.total_seek = run_total;
				m.end_of_run = (i + 2 == n_path);
				moves_due.push_back(m);
			end
			batch_cyls.delete();
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_MODE: cfg_mode = val[1:0];
			REG_DISK_MAX: cfg_disk_max = val;
			REG_HEAD_START: cfg_head = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic add_req(input logic [CYL_W-1:0] cyl, input logic last);
		req_t r;
		r.cylinder = cyl;
		r.last = last;
		pending_reqs.push_back(r);
		items_queued++;
	endtask

	// wait until every item is taken and every move has come back, then let the block go idle
	task automatic settle();
		while (items_taken != items_queued || moves_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [CYL_W-1:0] pick_cyl();
		logic [CYL_W-1:0] c;
		case ($urandom_range(9))
			0: c = '0;
			1: c = 16'hFFFF;
			2: c = cfg_head;
			3: c = cfg_head + CYL_W'($urandom_range(4)) - CYL_W'(2);
			4: c = cfg_disk_max + CYL_W'($urandom_range(4)) - CYL_W'(2);
			5: c = CYL_W'($urandom_range(255));
			default: c = CYL_W'($urandom_range(16'hFFFF));
		endcase
		return c;
	endfunction

	function automatic logic [CYL_W-1:0] pick_reg16();
		case ($urandom_range(5))
			0: return '0;
			1: return 16'hFFFF;
			2: return CYL_W'($urandom_range(1023));
			default: return CYL_W'($urandom_range(16'hFFFF));
		endcase
	endfunction

	task automatic set_random_config();
		int r;
		r = $urandom_range(9);
		write_reg(REG_MODE, CFG_DATA_W'((r < 3) ? MODE_FCFS : (r < 6) ? MODE_SCAN :
			(r < 9) ? MODE_CSCAN : MODE_UNUSED));
		write_reg(REG_DISK_MAX, pick_reg16());
		write_reg(REG_HEAD_START, pick_reg16());
	endtask

	task automatic add_batch();
		int size, i;
		// now and then a batch near or past the size of the store
		size = ($urandom_range(15) == 0) ? $urandom_range(MAX_REQUESTS - 2, MAX_REQUESTS + 4)
			: $urandom_range(1, 8);
		for (i = 0; i < size; i++)
			add_req(pick_cyl(), i == size - 1);
	endtask

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || req_took) begin
			req_took = 1'b0;
			if (pending_reqs.size() > 0 &&
				((cycle_count >= CALM_FROM && cycle_count < CALM_TO) || $urandom_range(99) >= 14)) begin
				req <= pending_reqs.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// move receiver, with one long hold-off to back the block up
	always @(negedge clk) begin
		if (!arst_n) begin
			move_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			move_ready <= 1'b0;
		end else if (!stall_done && items_taken >= HOLD_AFTER) begin
			stall_done = 1'b1;
			stall_left = HOLD_CYCLES;
			move_ready <= 1'b0;
		end else begin
			move_ready <= (cycle_count >= CALM_FROM && cycle_count < CALM_TO) ||
				$urandom_range(99) >= 14;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready) begin
				take_request(req);
				items_taken++;
				req_took = 1'b1;
			end
			if (move_valid && move_ready) begin
				if (moves_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected move: from %0d to %0d dist %0d total %0d end %0b",
							move.from_pos, move.to_pos, move.distance, move.total_seek,
							move.end_of_run);
				end else begin
					want = moves_due.pop_front();
					if (move.from_pos !== want.from_pos || move.to_pos !== want.to_pos ||
						move.distance !== want.distance || move.total_seek !== want.total_seek ||
						move.end_of_run !== want.end_of_run) begin
						mismatches++;
						if (mismatches <= 10)
							$display("move mismatch: expected %0d->%0d dist %0d total %0d end %0b,",
								want.from_pos, want.to_pos, want.distance, want.total_seek,
								want.end_of_run,
								" got %0d->%0d dist %0d total %0d end %0b",
								move.from_pos, move.to_pos, move.distance,
								move.total_seek, move.end_of_run);
					end
				end
			end
		end
	end

	// watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles = 0;
		end else begin
			cycle_count++;
			if ((req_valid && req_ready) || (move_valid && move_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// reset configuration: fcfs from cylinder 0, extremes and a single-request batch
		add_req(16'hFFFF, 1'b0);
		add_req(16'h0000, 1'b0);
		add_req(16'h8000, 1'b1);
		add_req(16'h0000, 1'b1);
		settle();

		// scan with a request at the head, one past the end and an all-lower batch
		write_reg(REG_MODE, CFG_DATA_W'(MODE_SCAN));
		write_reg(REG_DISK_MAX, 16'd1000);
		write_reg(REG_HEAD_START, 16'd500);
		add_req(16'd500, 1'b0);
		add_req(16'd700, 1'b0);
		add_req(16'd10, 1'b0);
		add_req(16'd2000, 1'b0);
		add_req(16'd499, 1'b1);
		add_req(16'd123, 1'b1);
		settle();

		// circular scan from the top cylinder
		write_reg(REG_MODE, CFG_DATA_W'(MODE_CSCAN));
		write_reg(REG_DISK_MAX, 16'hFFFF);
		write_reg(REG_HEAD_START, 16'hFFFF);
		add_req(16'd0, 1'b0);
		add_req(16'hFFFF, 1'b0);
		add_req(16'd100, 1'b1);
		settle();

		// head beyond the sweep end
		write_reg(REG_DISK_MAX, 16'd0);
		write_reg(REG_HEAD_START, 16'd40000);
		add_req(16'd40000, 1'b0);
		add_req(16'd5, 1'b0);
		add_req(16'd60000, 1'b1);
		settle();
		write_reg(REG_MODE, CFG_DATA_W'(MODE_SCAN));
		add_req(16'd40001, 1'b0);
		add_req(16'd3, 1'b1);
		settle();

		// unused mode runs as fcfs; zero-length moves
		write_reg(REG_MODE, CFG_DATA_W'(MODE_UNUSED));
		write_reg(REG_HEAD_START, 16'd7);
		add_req(16'd7, 1'b0);
		add_req(16'd7, 1'b1);
		settle();

		while (items_queued < ITEM_GOAL) begin
			set_random_config();
			repeat ($urandom_range(3, 8)) add_batch();
			settle();
		end

		if (mismatches == 0 && moves_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/dsos_pkg.sv
hw/rtl/dsos_ram.sv
hw/rtl/dsos_front.sv
hw/rtl/dsos_queue.sv
hw/rtl/dsos_back.sv
hw/rtl/disk_seek_order_scheduler.sv
sim/tb_disk_seek_order_scheduler.sv
